@@ sv/leg_setpoint_ramp_planner_assert.svh @@
// Assertion shorthands for the leg setpoint ramp planner.
`ifndef LEG_SETPOINT_RAMP_PLANNER_ASSERT_SVH
`define LEG_SETPOINT_RAMP_PLANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSRP_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lsrp: same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define LSRP_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lsrp: next-cycle implication violated");

`endif

@@ sv/lsrp_pkg.sv @@
`timescale 1ns / 1ps

package lsrp_pkg;

   // Largest angle increment per transaction, Q8.16
   localparam logic [22:0] ANGLE_STEP_LIMIT = 23'd655;
   // 0.02 rad in Q8.16 (1310.72), an error counts as large above this
   localparam logic [23:0] ERROR_THRESHOLD = 24'd1310;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_PITCH_GAIN        = 3'd0,
      CSR_ANGLE_LIMIT       = 3'd1,
      CSR_VELOCITY_STEP     = 3'd2,
      CSR_VELOCITY_LIMIT    = 3'd3,
      CSR_TORQUE_SPEED_THR  = 3'd4,
      CSR_TORQUE_HIGH_LEVEL = 3'd5,
      CSR_TORQUE_HOLD_LEVEL = 3'd6,
      CSR_TORQUE_STEP       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [23:0] pitch;
      logic signed [23:0] velocity_cmd;
      logic signed [23:0] pitch_error;
   } lsrp_req_type;

   typedef struct packed {
      logic signed [23:0] target_angle;
      logic signed [23:0] target_velocity;
      logic signed [23:0] feedforward_torque;
   } lsrp_rsp_type;

   // Clamp to +-lim; lim never exceeds the 24-bit signed range
   function automatic logic signed [23:0] sat_sym(input logic signed [32:0] v,
                                                   input logic [22:0] lim);
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      logic signed [32:0] r;
      hi = signed'({10'd0, lim});
      lo = -hi;
      r  = v;
      if (v > hi) r = hi;
      if (v < lo) r = lo;
      return r[23:0];
   endfunction

   // Magnitude; the most negative value maps to 2^23 exactly
   function automatic logic [23:0] mag24(input logic signed [23:0] v);
      logic signed [23:0] n;
      n = -v;
      return v[23] ? unsigned'(n) : unsigned'(v);
   endfunction

endpackage

@@ sv/leg_setpoint_ramp_planner.sv @@
`timescale 1ns / 1ps
`include "leg_setpoint_ramp_planner_assert.svh"

// Leg setpoint ramp planner. Takes one transaction per clock cycle unless
// stalled and returns one result per transaction: the item lands in an input
// register, and once the output register is free one pass of logic (a 24x25
// multiply for the angle increment, then the clamp, slew and torque ramp adds)
// updates the four state registers and loads the output register, which
// holds the result until the receiver takes it. That state update path sets
// the one-item-per-cycle rate. The output register and the input register
// decouple the two sides, so one new item is still taken while a finished
// result waits. csr_ready is always high; write configuration only while no
// transaction is in flight.
module leg_setpoint_ramp_planner
   import lsrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lsrp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lsrp_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [22:0]  csr_data
);

   // Configuration registers
   logic [22:0] pitch_gain_ff, angle_limit_ff, velocity_step_ff, velocity_limit_ff;
   logic [22:0] speed_thr_ff, torque_high_ff, torque_hold_ff, torque_step_ff;

   // Pipeline registers
   logic         in_valid_ff, in_valid_in;
   lsrp_req_type in_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   lsrp_rsp_type rsp_ff, rsp_in;

   // Planner state
   logic signed [23:0] prev_pitch_ff, prev_pitch_in;
   logic signed [23:0] angle_sum_ff, angle_sum_in;
   logic signed [23:0] prev_vel_ff, prev_vel_in;
   logic signed [23:0] held_torque_ff, held_torque_in;

   logic advance;
   logic req_take;

   // Datapath intermediates
   logic signed [24:0] pitch_delta;
   logic signed [47:0] gain_product;
   logic signed [31:0] incr_raw;
   logic signed [23:0] incr;
   logic signed [23:0] vel_step;
   logic signed [24:0] vel_sum;
   logic signed [23:0] vel_out;
   logic [23:0]        vel_mag, err_mag;
   logic               torque_high;
   logic [22:0]        torque_level;
   logic signed [23:0] torque_target;
   logic signed [24:0] torque_up, torque_dn;

   assign csr_ready = 1'b1;

   // Handshake: compute stage moves when the output register frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Angle accumulator: floor(gain * delta / 2^16), clamped twice
   always_comb begin
      pitch_delta  = 25'(in_ff.pitch) - 25'(prev_pitch_ff);
      gain_product = 48'(signed'({1'b0, pitch_gain_ff})) * 48'(pitch_delta);
      incr_raw     = gain_product[47:16];
      incr         = sat_sym(33'(incr_raw), ANGLE_STEP_LIMIT);
      angle_sum_in = sat_sym(33'(angle_sum_ff) + 33'(incr), angle_limit_ff);
      prev_pitch_in = in_ff.pitch;
   end

   // Velocity slew; stored value stays unclamped
   always_comb begin
      vel_step    = sat_sym(33'(in_ff.velocity_cmd) - 33'(prev_vel_ff), velocity_step_ff);
      vel_sum     = 25'(prev_vel_ff) + 25'(vel_step);
      prev_vel_in = vel_sum[23:0];
      vel_out     = sat_sym(33'(prev_vel_in), velocity_limit_ff);
   end

   // Feedforward torque target and ramp
   always_comb begin
      vel_mag       = mag24(vel_out);
      err_mag       = mag24(in_ff.pitch_error);
      torque_high   = (vel_mag > 24'(speed_thr_ff)) && (err_mag > ERROR_THRESHOLD);
      torque_level  = torque_high ? torque_high_ff : torque_hold_ff;
      torque_target = vel_out[23] ? -signed'({1'b0, torque_level})
                                  : signed'({1'b0, torque_level});
      torque_up     = 25'(held_torque_ff) + signed'({2'b00, torque_step_ff});
      torque_dn     = 25'(held_torque_ff) - signed'({2'b00, torque_step_ff});
      held_torque_in = held_torque_ff;
      if (torque_target > held_torque_ff) begin
         held_torque_in = (torque_up > 25'(torque_target)) ? torque_target
                                                           : torque_up[23:0];
      end else if (torque_target < held_torque_ff) begin
         held_torque_in = (torque_dn < 25'(torque_target)) ? torque_target
                                                           : torque_dn[23:0];
      end
   end

   always_comb begin
      rsp_in.target_angle       = angle_sum_in;
      rsp_in.target_velocity    = vel_out;
      rsp_in.feedforward_torque = held_torque_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_gain_ff     <= 23'd65536;
         angle_limit_ff    <= 23'd65536;
         velocity_step_ff  <= 23'd655;
         velocity_limit_ff <= 23'd327680;
         speed_thr_ff      <= 23'd6554;
         torque_high_ff    <= 23'd327680;
         torque_hold_ff    <= 23'd0;
         torque_step_ff    <= 23'd655;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PITCH_GAIN:        pitch_gain_ff     <= csr_data;
            CSR_ANGLE_LIMIT:       angle_limit_ff    <= csr_data;
            CSR_VELOCITY_STEP:     velocity_step_ff  <= csr_data;
            CSR_VELOCITY_LIMIT:    velocity_limit_ff <= csr_data;
            CSR_TORQUE_SPEED_THR:  speed_thr_ff      <= csr_data;
            CSR_TORQUE_HIGH_LEVEL: torque_high_ff    <= csr_data;
            CSR_TORQUE_HOLD_LEVEL: torque_hold_ff    <= csr_data;
            CSR_TORQUE_STEP:       torque_step_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_pitch_ff  <= '0;
         angle_sum_ff   <= '0;
         prev_vel_ff    <= '0;
         held_torque_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_pitch_ff  <= prev_pitch_in;
            angle_sum_ff   <= angle_sum_in;
            prev_vel_ff    <= prev_vel_in;
            held_torque_ff <= held_torque_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks
   `LSRP_ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && rsp_valid_ff)
   `LSRP_ASSERT_IMPLY(a_rsp_from_input, clock, reset, $rose(rsp_valid_ff), $past(in_valid_ff))
   `LSRP_ASSERT_NEXT(a_torque_matches_state, clock, reset, advance,
                     rsp_ff.feedforward_torque == held_torque_ff)
   `LSRP_ASSERT_NEXT(a_angle_matches_state, clock, reset, advance,
                     rsp_ff.target_angle == angle_sum_ff)

endmodule

@@ tb/leg_setpoint_ramp_planner_test.sv @@
`timescale 1ns / 1ps

module leg_setpoint_ramp_planner_test;
   import lsrp_pkg::*;

   // One tick waiting to be offered, with an optional hand-typed result
   typedef struct {
      lsrp_req_type tick;
      bit           typed;
      lsrp_rsp_type want;
   } pending_tick_type;

   // Directed row: inputs, then the result when it is obvious by inspection
   typedef struct packed {
      logic signed [23:0] pitch;
      logic signed [23:0] raw;
      logic signed [23:0] err;
      logic               typed;
      logic signed [23:0] angle;
      logic signed [23:0] vel;
      logic signed [23:0] torque;
   } step_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam int RANDOM_PHASES = 10;
   localparam int TICKS_PER_PHASE = 170;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int DRAIN_GUARD = 50000;

   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      // after reset everything is zero
      '{24'sd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0, 24'sd0},
      // largest values: both steps clamp, speed still below threshold
      '{24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b1, 24'sd655, 24'sd655, 24'sd0},
      // most negative values: both steps clamp back to zero
      '{-24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b1, 24'sd0, 24'sd0, 24'sd0},
      // speed ramps past the threshold with a large error, torque builds up
      '{24'sd100, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd200, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd300, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd400, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd500, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd600, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd700, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd800, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd900, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd1000, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd1100, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd1150, 24'sd8388607, 24'sd2000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      // error exactly at the threshold is not large
      '{24'sd1200, 24'sd8388607, 24'sd1310, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd1300, 24'sd8388607, 24'sd1311, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd1300, 24'sd8388607, -24'sd1311, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      // reverse the command, most negative error magnitude
      '{24'sd1300, -24'sd8388608, -24'sd8388608, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd0, -24'sd8388608, 24'sd5000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{-24'sd8388608, 24'sd0, 24'sd8388607, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd8388607, -24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{-24'sd1, 24'sd1, 24'sd1, 1'b0, 24'sd0, 24'sd0, 24'sd0}
   };

   localparam logic [22:0] RESET_SETTINGS [8] = '{
      23'd65536, 23'd65536, 23'd655, 23'd327680,
      23'd6554, 23'd327680, 23'd0, 23'd655
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lsrp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lsrp_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [22:0]  csr_data = '0;

   // Planner state and register copy
   logic [22:0] plan_regs [8];
   longint      last_pitch;
   longint      angle_acc;
   longint      last_velocity;
   longint      torque_acc;

   pending_tick_type pending_ticks[$];
   lsrp_rsp_type     planned_setpoints[$];
   int               error_count = 0;
   bit               no_idle = 1'b0;
   int               holdoff_req = 0;
   int               holdoff_served = 0;
   int               stall_run = 0;
   int               walk_pitch = 0;
   int               raw_goal = 0;

   leg_setpoint_ramp_planner uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint bound(longint v, longint lim);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic longint absval(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Advance the planner by one tick and return its setpoints
   function automatic lsrp_rsp_type plan_tick(lsrp_req_type t);
      longint       pitch_v;
      longint       raw_v;
      longint       err_v;
      longint       incr;
      longint       vel_out;
      longint       level;
      longint       aim;
      bit           high_torque;
      lsrp_rsp_type r;
      pitch_v = t.pitch;
      raw_v   = t.velocity_cmd;
      err_v   = t.pitch_error;

      // angle increment, floor of gain times delta, then both clamps
      incr = (longint'(plan_regs[CSR_PITCH_GAIN]) * (pitch_v - last_pitch)) >>> 16;
      last_pitch = pitch_v;
      incr = bound(incr, longint'(ANGLE_STEP_LIMIT));
      angle_acc = bound(angle_acc + incr, longint'(plan_regs[CSR_ANGLE_LIMIT]));

      // slew toward the raw command, only the output is bounded
      last_velocity = last_velocity +
         bound(raw_v - last_velocity, longint'(plan_regs[CSR_VELOCITY_STEP]));
      vel_out = bound(last_velocity, longint'(plan_regs[CSR_VELOCITY_LIMIT]));

      // torque target and ramp
      high_torque = absval(vel_out) > longint'(plan_regs[CSR_TORQUE_SPEED_THR]) &&
                    absval(err_v) > longint'(ERROR_THRESHOLD);
      level = high_torque ? longint'(plan_regs[CSR_TORQUE_HIGH_LEVEL])
                          : longint'(plan_regs[CSR_TORQUE_HOLD_LEVEL]);
      aim = (vel_out < 0) ? -level : level;
      if (aim > torque_acc) begin
         torque_acc = torque_acc + longint'(plan_regs[CSR_TORQUE_STEP]);
         if (torque_acc > aim) torque_acc = aim;
      end else if (aim < torque_acc) begin
         torque_acc = torque_acc - longint'(plan_regs[CSR_TORQUE_STEP]);
         if (torque_acc < aim) torque_acc = aim;
      end

      r.target_angle       = 24'(angle_acc);
      r.target_velocity    = 24'(vel_out);
      r.feedforward_torque = 24'(torque_acc);
      return r;
   endfunction

   // Mostly smooth pitch walks and steady commands, some full-range noise
   function automatic lsrp_req_type random_tick();
      lsrp_req_type t;
      int           kind;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         t.pitch        = 24'($urandom);
         t.velocity_cmd = 24'($urandom);
         t.pitch_error  = 24'($urandom);
      end else begin
         if ($urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 3) == 0) raw_goal = int'(24'sh0 + $signed(24'($urandom)));
            else raw_goal = int'($urandom_range(0, 800000)) - 400000;
         end
         walk_pitch = walk_pitch + int'($urandom_range(0, 4000)) - 2000;
         if (walk_pitch > 8388607) walk_pitch = 8388607;
         if (walk_pitch < -8388608) walk_pitch = -8388608;
         t.pitch        = 24'(walk_pitch);
         t.velocity_cmd = 24'(raw_goal + int'($urandom_range(0, 200)) - 100);
         t.pitch_error  = 24'(int'($urandom_range(0, 6000)) - 3000);
      end
      return t;
   endfunction

   function automatic logic [22:0] pick_setting(logic [22:0] typical);
      case ($urandom_range(0, 5))
         0: return 23'($urandom);
         1: return 23'($urandom_range(0, 2000));
         2: return 23'd0;
         3: return 23'h7FFFFF;
         default: return typical;
      endcase
   endfunction

   task automatic write_csr(csr_index_type idx, logic [22:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      plan_regs[idx] = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_tick(lsrp_req_type t);
      pending_tick_type p;
      p.tick  = t;
      p.typed = 1'b0;
      p.want  = '0;
      pending_ticks.push_back(p);
   endtask

   // Wait until every tick is taken and every setpoint has come back
   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((pending_ticks.size() != 0 || req_valid || planned_setpoints.size() != 0)
             && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= DRAIN_GUARD) begin
         error_count++;
         $display("%0t: timeout, %0d setpoints still outstanding", $time,
                  planned_setpoints.size());
      end
   endtask

   task automatic compare_field(string name, logic signed [23:0] want,
                                logic signed [23:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Sender: offer the next tick, hold it while stalled, idle at random
   always @(posedge clock) begin : drive_ticks
      pending_tick_type head;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            head = pending_ticks.pop_front();
            if (head.typed) begin
               void'(plan_tick(head.tick));
               planned_setpoints.push_back(head.want);
            end else begin
               planned_setpoints.push_back(plan_tick(head.tick));
            end
         end
         if (!(req_valid && req_stall)) begin
            if (pending_ticks.size() != 0 && (no_idle || $urandom_range(0, 99) >= 31)) begin
               req_valid <= 1'b1;
               req_data  <= pending_ticks[0].tick;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (holdoff_served != holdoff_req) begin
         holdoff_served = holdoff_req;
         stall_run = HOLDOFF_CYCLES;
      end
      if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 31);
      end
   end

   // Compare each accepted transaction with the oldest planned setpoint
   always @(posedge clock) begin : check_setpoints
      lsrp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (planned_setpoints.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, actual %0d %0d %0d", $time,
                     rsp_data.target_angle, rsp_data.target_velocity,
                     rsp_data.feedforward_torque);
         end else begin
            want = planned_setpoints.pop_front();
            compare_field("target_angle", want.target_angle, rsp_data.target_angle);
            compare_field("target_velocity", want.target_velocity,
                          rsp_data.target_velocity);
            compare_field("feedforward_torque", want.feedforward_torque,
                          rsp_data.feedforward_torque);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : main_sequence
      pending_tick_type p;
      logic [22:0]      settings [8];
      for (int i = 0; i < 8; i++) plan_regs[i] = RESET_SETTINGS[i];
      last_pitch    = 0;
      angle_acc     = 0;
      last_velocity = 0;
      torque_acc    = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset settings
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         p.tick.pitch        = DIRECTED[i].pitch;
         p.tick.velocity_cmd = DIRECTED[i].raw;
         p.tick.pitch_error  = DIRECTED[i].err;
         p.typed                   = DIRECTED[i].typed;
         p.want.target_angle       = DIRECTED[i].angle;
         p.want.target_velocity    = DIRECTED[i].vel;
         p.want.feedforward_torque = DIRECTED[i].torque;
         pending_ticks.push_back(p);
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         repeat (3) @(posedge clock);
         for (int i = 0; i < 8; i++) begin
            case (ph)
               0: settings[i] = 23'h7FFFFF;
               1: settings[i] = 23'd0;
               2: settings[i] = RESET_SETTINGS[i];
               default: settings[i] = pick_setting(RESET_SETTINGS[i]);
            endcase
            write_csr(csr_index_type'(i), settings[i]);
         end
         no_idle = (ph == 3);
         for (int n = 0; n < TICKS_PER_PHASE; n++) queue_tick(random_tick());
         // back up the output while the sender keeps offering
         if (ph == 5 || ph == 8) holdoff_req++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/lsrp_pkg.sv
sv/leg_setpoint_ramp_planner.sv
tb/leg_setpoint_ramp_planner_test.sv
